FILE: hw/rtl/ascg_pkg.sv
package ascg_pkg;

    localparam int RAW_W  = 16;
    localparam int ALN_W  = 14;
    localparam int SENS_W = 18;
    localparam int V_W    = 32;
    localparam int D_W    = 33;
    localparam int P_W    = 49;
    localparam int OUT_W  = 32;
    localparam int CAL_SH = 22;
    localparam int OFF_SH = 13;
    localparam int N_AXES = 3;
    localparam int IDX_W  = 3;
    localparam int REG_W  = 48;

    localparam logic [15:0] GAIN_ONE = 16'h4000;
    localparam logic [REG_W-1:0] GAINS_RST = 48'h4000_4000_4000;

    localparam logic [3:0] QB_10 = 4'd10;
    localparam logic [3:0] QB_12 = 4'd12;

    localparam logic signed [P_W-1:0] SAT_HI = P_W'(64'sd2147483647);
    localparam logic signed [P_W-1:0] SAT_LO = P_W'(-64'sd2147483648);

    typedef enum logic [IDX_W-1:0] {
        CFG_LOW_RES = 3'd0,
        CFG_FSCALE  = 3'd1,
        CFG_QBITS   = 3'd2,
        CFG_CAL_EN  = 3'd3,
        CFG_OFFSETS = 3'd4,
        CFG_GAINS   = 3'd5
    } t_cfg_idx;

    // Per-lane settings; offset and gain already reflect the calibration enable.
    typedef struct packed {
        logic        low_res;
        logic [1:0]  full_scale;
        logic [3:0]  quant_bits;
        logic [15:0] offset;
        logic [15:0] gain;
    } t_lane_cfg;

    // Sensitivity in units of 2^-24 g per LSB of the native resolution.
    function automatic logic [SENS_W-1:0] sens_lookup(input logic low_res,
                                                      input logic [1:0] fs);
        logic [SENS_W-1:0] s;
        s = '0;
        if (low_res) begin
            unique case (fs)
                2'd0: s = 18'd16375;
                2'd1: s = 18'd32749;
                2'd2: s = 18'd65498;
                2'd3: s = 18'd130997;
                default: s = '0;
            endcase
        end else begin
            unique case (fs)
                2'd0: s = 18'd4094;
                2'd1: s = 18'd8187;
                2'd2: s = 18'd16375;
                2'd3: s = 18'd32749;
                default: s = '0;
            endcase
        end
        return s;
    endfunction

endpackage

FILE: hw/rtl/ascg_cfg.sv
module ascg_cfg
    import ascg_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  logic [IDX_W-1:0]        i_cfg_index,
    input  logic [REG_W-1:0]        i_cfg_data,
    output logic                    o_cfg_ready,
    output t_lane_cfg               o_lane_cfg [N_AXES]
);

    logic             r_low_res;
    logic [1:0]       r_full_scale;
    logic [3:0]       r_quant_bits;
    logic             r_cal_enable;
    logic [REG_W-1:0] r_offsets;
    logic [REG_W-1:0] r_gains;
    logic             r_ready;
    logic             wr;

    assign wr = i_cfg_valid && r_ready;
    assign o_cfg_ready = r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_res    <= 1'b0;
            r_full_scale <= '0;
            r_quant_bits <= '0;
            r_cal_enable <= 1'b0;
            r_offsets    <= '0;
            r_gains      <= GAINS_RST;
            r_ready      <= 1'b0;
        end else begin
            r_ready <= 1'b1;
            if (wr) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_LOW_RES: r_low_res    <= i_cfg_data[0];
                    CFG_FSCALE:  r_full_scale <= i_cfg_data[1:0];
                    CFG_QBITS:   r_quant_bits <= i_cfg_data[3:0];
                    CFG_CAL_EN:  r_cal_enable <= i_cfg_data[0];
                    CFG_OFFSETS: r_offsets    <= i_cfg_data;
                    CFG_GAINS:   r_gains      <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // With calibration off, a zero offset and unity gain give floor(v / 2^8).
    always_comb begin
        for (int i = 0; i < N_AXES; i++) begin
            o_lane_cfg[i].low_res    = r_low_res;
            o_lane_cfg[i].full_scale = r_full_scale;
            o_lane_cfg[i].quant_bits = r_quant_bits;
            o_lane_cfg[i].offset     = r_cal_enable ? r_offsets[16*i +: 16] : 16'd0;
            o_lane_cfg[i].gain       = r_cal_enable ? r_gains[16*i +: 16] : GAIN_ONE;
        end
    end

endmodule

FILE: hw/rtl/ascg_lane.sv
module ascg_lane
    import ascg_pkg::*;
(
    input  logic                    i_clk,
    input  logic signed [RAW_W-1:0] i_raw,
    input  t_lane_cfg               i_cfg,
    output logic signed [P_W-1:0]   o_prod
);

    logic signed [ALN_W-1:0] aligned;
    logic signed [ALN_W-1:0] quant;
    logic [2:0]              drop;
    logic [SENS_W-1:0]       sens;
    logic signed [V_W-1:0]   n_v;
    logic signed [V_W-1:0]   r_v;
    logic signed [D_W-1:0]   n_d;
    logic signed [D_W-1:0]   r_d;
    logic signed [P_W-1:0]   n_p;
    logic signed [P_W-1:0]   r_p;

    always_comb begin
        aligned = i_cfg.low_res ? ALN_W'(i_raw >>> 4) : ALN_W'(i_raw >>> 2);
        drop = 3'd0;
        if (i_cfg.low_res) begin
            if (i_cfg.quant_bits == QB_10) drop = 3'd2;
        end else begin
            if (i_cfg.quant_bits == QB_10) drop = 3'd4;
            else if (i_cfg.quant_bits == QB_12) drop = 3'd2;
        end
        // Floor shift right then left is the same as clearing the low bits.
        quant = aligned & ~((ALN_W'(1) << drop) - ALN_W'(1));
        sens  = sens_lookup(i_cfg.low_res, i_cfg.full_scale);
        n_v   = V_W'(quant) * V_W'($signed({1'b0, sens}));
    end

    assign n_d = D_W'(r_v) - (D_W'($signed(i_cfg.offset)) <<< OFF_SH);
    assign n_p = P_W'(r_d) * P_W'($signed(i_cfg.gain));

    always_ff @(posedge i_clk) begin
        r_v <= n_v;
        r_d <= n_d;
        r_p <= n_p;
    end

    assign o_prod = r_p;

endmodule

FILE: hw/rtl/ascg_merge.sv
module ascg_merge
    import ascg_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic signed [P_W-1:0]   i_prod [N_AXES],
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_accel [N_AXES]
);

    logic                    r_valid;
    logic signed [OUT_W-1:0] r_accel [N_AXES];
    logic signed [OUT_W-1:0] n_accel [N_AXES];
    logic signed [P_W-1:0]   sh [N_AXES];

    always_comb begin
        for (int i = 0; i < N_AXES; i++) begin
            sh[i] = i_prod[i] >>> CAL_SH;
            if (sh[i] > SAT_HI) begin
                n_accel[i] = OUT_W'(SAT_HI);
            end else if (sh[i] < SAT_LO) begin
                n_accel[i] = OUT_W'(SAT_LO);
            end else begin
                n_accel[i] = OUT_W'(sh[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N_AXES; i++) begin
            r_accel[i] <= n_accel[i];
        end
    end

    assign o_valid = r_valid;
    assign o_accel = r_accel;

endmodule

FILE: hw/rtl/accel_sample_to_calibrated_g.sv
// Accelerometer sample to calibrated acceleration.
//
// Input: pulse i_start with a three-axis sample on i_raw_x/y/z; the item is
// taken at a rising edge where i_start is high and o_busy is low. o_busy is
// high during reset and in the first cycle after it, so one item can enter
// every cycle once reset is over.
// Output: o_valid is high for exactly one cycle with o_accel_x/y/z, in units
// of 2^-16 g. The receiver cannot stall; every result must be taken then.
// Timing: the valid bit of a taken item passes r_vld[0..2] and then the merge
// valid register, in step with its data in the lane and merge registers.
// Throughput: one item per cycle once reset is over, set by the three per-axis
// lanes, each a three-register chain (sensitivity multiply, offset subtract,
// gain multiply) feeding the per-axis floor-shift and saturation registers.
// Configuration: write i_cfg_index / i_cfg_data with i_cfg_valid while
// o_cfg_ready is high; indices 0..5 are low-res mode, full scale, quantize
// bits, calibration enable, offsets and gains; others are ignored. Write only
// while no item is in flight.
// Reset (i_rst_n low, synchronous) drops in-flight items and restores the
// register defaults (unity gains, zero offsets, 14-bit 2g mode).
module accel_sample_to_calibrated_g
    import ascg_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  logic signed [RAW_W-1:0] i_raw_x,
    input  logic signed [RAW_W-1:0] i_raw_y,
    input  logic signed [RAW_W-1:0] i_raw_z,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [IDX_W-1:0]        i_cfg_index,
    input  logic [REG_W-1:0]        i_cfg_data,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_accel_x,
    output logic signed [OUT_W-1:0] o_accel_y,
    output logic signed [OUT_W-1:0] o_accel_z
);

    t_lane_cfg               lane_cfg [N_AXES];
    logic signed [RAW_W-1:0] raw      [N_AXES];
    logic signed [P_W-1:0]   prod     [N_AXES];
    logic signed [OUT_W-1:0] accel    [N_AXES];
    logic                    r_busy;
    logic [2:0]              r_vld;
    logic                    accept;

    assign accept = i_start && !r_busy;
    assign o_busy = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[1:0], accept};
        end
    end

    ascg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_lane_cfg  (lane_cfg)
    );

    assign raw[0] = i_raw_x;
    assign raw[1] = i_raw_y;
    assign raw[2] = i_raw_z;

    for (genvar g = 0; g < N_AXES; g++) begin : g_lane
        ascg_lane u_lane (
            .i_clk  (i_clk),
            .i_raw  (raw[g]),
            .i_cfg  (lane_cfg[g]),
            .o_prod (prod[g])
        );
    end

    ascg_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld[2]),
        .i_prod  (prod),
        .o_valid (o_valid),
        .o_accel (accel)
    );

    assign o_accel_x = accel[0];
    assign o_accel_y = accel[1];
    assign o_accel_z = accel[2];

endmodule

FILE: hw/rtl/ascg_checker.sv
module ascg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_valid,
    input logic        o_cfg_ready
);

    // Every accepted item produces a result.
    a_item_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##4 o_valid)
        else $error("accepted item produced no result");

    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, 4))
        else $error("result without an accepted item");

    // Once out of reset, the block keeps accepting items.
    a_busy_stays_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy |=> !o_busy)
        else $error("busy reasserted outside reset");

    a_cfg_ready_with_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy |-> o_cfg_ready)
        else $error("configuration port not ready while input is open");

endmodule

bind accel_sample_to_calibrated_g ascg_checker u_ascg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .o_valid     (o_valid),
    .o_cfg_ready (o_cfg_ready)
);
